// ===== src/aligned_ring_reserve_core_macros.svh =====
// Assertion macros used by the arr_checker file.
`ifndef ALIGNED_RING_RESERVE_CORE_MACROS_SVH
`define ALIGNED_RING_RESERVE_CORE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ARR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define ARR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/arr_pkg.sv =====
package arr_pkg;

  localparam int unsigned POS_WIDTH_DEF = 32;

  localparam int unsigned CFG_W    = 5;
  localparam int unsigned SIZE_W   = 25;
  localparam int unsigned ALIGN_W  = 4;
  localparam int unsigned REL_W    = 32;
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned END_W    = 32;

  localparam int unsigned CAP_W    = 25;
  localparam int unsigned AMASK_W  = 15;
  localparam int unsigned LAG_W    = 25;
  localparam int unsigned TOTAL_W  = 27;

  localparam logic [CFG_W-1:0] CAP_LOG2_RESET = CFG_W'(16);
  localparam logic [CFG_W-1:0] CAP_LOG2_MIN   = CFG_W'(4);
  localparam logic [CFG_W-1:0] CAP_LOG2_MAX   = CFG_W'(24);

  localparam logic OP_RESERVE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic                ok;
    logic [OFFSET_W-1:0] offset;
    logic [END_W-1:0]    end_position;
  } arr_result_t;

endpackage

// ===== src/aligned_ring_reserve_core.sv =====
// Ring-buffer space allocator: takes one reserve or release request per clock
// while the output is not stalled, and answers each with one result (input
// register, then a single-pass datapath on the head and tail registers into
// the result register). A reserve aligns the head, skips to the next ring
// boundary if the region would straddle it, and fails with ok low and the head
// unchanged when the span from the tail exceeds the capacity. The capacity
// register (log2, reset 16, clamped to 4..24) takes writes in any cycle; write
// it only while no request is in flight.
module aligned_ring_reserve_core #(
  parameter int unsigned POS_WIDTH = arr_pkg::POS_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [arr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [arr_pkg::SIZE_W-1:0]    request_size,
  input  logic [arr_pkg::ALIGN_W-1:0]   align_log2,
  input  logic [arr_pkg::REL_W-1:0]     release_position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic [arr_pkg::OFFSET_W-1:0]  offset,
  output logic [arr_pkg::END_W-1:0]     end_position
);
  import arr_pkg::*;

  logic [CFG_W-1:0]     cap_log2;
  logic [POS_WIDTH-1:0] head;
  logic [POS_WIDTH-1:0] tail;
  logic [POS_WIDTH-1:0] head_next;
  logic [POS_WIDTH-1:0] tail_next;

  logic                 s1_valid;
  logic                 s1_op;
  logic [SIZE_W-1:0]    s1_size;
  logic [ALIGN_W-1:0]   s1_align;
  logic [REL_W-1:0]     s1_rel;
  logic                 s1_advance;

  arr_result_t          res_next;
  arr_result_t          res;

  assign cfg_ready  = 1'b1;
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;

  arr_alloc #(
    .POS_WIDTH(POS_WIDTH)
  ) u_alloc (
    .cap_log2         (cap_log2),
    .op               (s1_op),
    .request_size     (s1_size),
    .align_log2       (s1_align),
    .release_position (s1_rel),
    .head             (head),
    .tail             (tail),
    .head_next        (head_next),
    .tail_next        (tail_next),
    .result           (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_log2  <= CAP_LOG2_RESET;
      head      <= '0;
      tail      <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_log2 <= cfg_data;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_advance) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          head <= head_next;
          tail <= tail_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op    <= op;
      s1_size  <= request_size;
      s1_align <= align_log2;
      s1_rel   <= release_position;
    end
    if (s1_advance && s1_valid) begin
      res <= res_next;
    end
  end

  assign ok           = res.ok;
  assign offset       = res.offset;
  assign end_position = res.end_position;

endmodule

// ===== src/arr_alloc.sv =====
module arr_alloc #(
  parameter int unsigned POS_WIDTH = arr_pkg::POS_WIDTH_DEF
) (
  input  logic [arr_pkg::CFG_W-1:0]   cap_log2,
  input  logic                        op,
  input  logic [arr_pkg::SIZE_W-1:0]  request_size,
  input  logic [arr_pkg::ALIGN_W-1:0] align_log2,
  input  logic [arr_pkg::REL_W-1:0]   release_position,
  input  logic [POS_WIDTH-1:0]        head,
  input  logic [POS_WIDTH-1:0]        tail,
  output logic [POS_WIDTH-1:0]        head_next,
  output logic [POS_WIDTH-1:0]        tail_next,
  output arr_pkg::arr_result_t        result
);
  import arr_pkg::*;

  logic [CFG_W-1:0]     cl;
  logic [CAP_W-1:0]     cap;
  logic [CAP_W-1:0]     cap_mask;
  logic [AMASK_W-1:0]   amask;
  logic [POS_WIDTH-1:0] aligned;
  logic [AMASK_W-1:0]   pad;
  logic [OFFSET_W-1:0]  in_ring;
  logic [CAP_W-1:0]     room;
  logic [CAP_W-1:0]     skip;
  logic [POS_WIDTH-1:0] start_pos;
  logic [POS_WIDTH-1:0] end_pos;
  logic [POS_WIDTH-1:0] lag;
  logic [TOTAL_W-1:0]   total;
  logic                 fits;
  logic [POS_WIDTH-1:0] rel_pos;

  always_comb begin
    if (cap_log2 < CAP_LOG2_MIN) begin
      cl = CAP_LOG2_MIN;
    end else if (cap_log2 > CAP_LOG2_MAX) begin
      cl = CAP_LOG2_MAX;
    end else begin
      cl = cap_log2;
    end
  end

  assign cap      = CAP_W'(1) << cl;
  assign cap_mask = cap - CAP_W'(1);
  assign amask    = AMASK_W'((AMASK_W + 1)'(1) << align_log2) - AMASK_W'(1);

  assign aligned = (head + POS_WIDTH'(amask)) & ~POS_WIDTH'(amask);
  assign pad     = aligned[AMASK_W-1:0] - head[AMASK_W-1:0];
  assign in_ring = aligned[OFFSET_W-1:0] & cap_mask[OFFSET_W-1:0];
  assign room    = cap - CAP_W'(in_ring);
  assign skip    = ((in_ring != '0) && (room < request_size)) ? room : '0;

  assign start_pos = aligned + POS_WIDTH'(skip);
  assign end_pos   = start_pos + POS_WIDTH'(request_size);

  assign lag   = head - tail;
  assign total = TOTAL_W'(lag[LAG_W-1:0]) + TOTAL_W'(pad) + TOTAL_W'(skip)
               + TOTAL_W'(request_size);
  assign fits  = (lag <= POS_WIDTH'(cap)) && (total <= TOTAL_W'(cap));

  assign rel_pos = POS_WIDTH'(release_position);

  always_comb begin
    head_next           = head;
    tail_next           = tail;
    result.ok           = 1'b0;
    result.offset       = '0;
    result.end_position = '0;
    if (op == OP_RELEASE) begin
      tail_next           = rel_pos;
      result.ok           = 1'b1;
      result.end_position = END_W'(rel_pos);
    end else if (fits) begin
      head_next           = end_pos;
      result.ok           = 1'b1;
      result.offset       = start_pos[OFFSET_W-1:0] & cap_mask[OFFSET_W-1:0];
      result.end_position = END_W'(end_pos);
    end
  end

endmodule

// ===== src/arr_checker.sv =====
module arr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         ok,
  input logic [arr_pkg::OFFSET_W-1:0] offset,
  input logic [arr_pkg::END_W-1:0]    end_position
);
  `include "aligned_ring_reserve_core_macros.svh"

  `ARR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(ok) && $stable(offset) && $stable(end_position), "stalled result changed")
  `ARR_ASSERT_NOW(a_fail_zero, out_valid && !ok, offset == '0 && end_position == '0, "failed reserve carries nonzero fields")
  `ARR_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
  `ARR_ASSERT_NEXT(a_fill_stops, out_valid && !out_ready && in_valid && in_ready, out_ready || !in_ready, "accepted past a full pipeline")

endmodule

bind aligned_ring_reserve_core arr_checker u_arr_checker (.*);

// ===== tb/sv/ring_reserve_checker.sv =====
module ring_reserve_checker
  import arr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                op,
  input  logic [SIZE_W-1:0]   request_size,
  input  logic [ALIGN_W-1:0]  align_log2,
  input  logic [REL_W-1:0]    release_position,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                ok,
  input  logic [OFFSET_W-1:0] offset,
  input  logic [END_W-1:0]    end_position,
  output int                  outstanding,
  output int                  failures
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] POS_MASK = 64'h0000_0000_FFFF_FFFF;

  logic [CFG_W-1:0] cap_log2_q;
  logic [END_W-1:0] head_q;
  logic [END_W-1:0] tail_q;
  arr_result_t      expected_grants [$];
  int               mismatches = 0;

  function automatic arr_result_t allocate(input logic kind, input logic [SIZE_W-1:0] sz,
                                           input logic [ALIGN_W-1:0] al,
                                           input logic [REL_W-1:0] pos);
    arr_result_t res;
    int unsigned cl;
    logic [63:0] cap, amask, aligned, pad, in_ring, skip, start_pos, stop_pos, lag;
    res = '0;
    if (kind == OP_RELEASE) begin
      tail_q = pos;
      res.ok = 1'b1;
      res.end_position = pos;
      return res;
    end
    cl = cap_log2_q;
    if (cl < CAP_LOG2_MIN) cl = CAP_LOG2_MIN;
    if (cl > CAP_LOG2_MAX) cl = CAP_LOG2_MAX;
    cap = 64'd1 << cl;
    amask = (64'd1 << al) - 64'd1;
    aligned = (({32'd0, head_q} + amask) & ~amask) & POS_MASK;
    pad = (aligned - {32'd0, head_q}) & POS_MASK;
    in_ring = aligned & (cap - 64'd1);
    skip = 64'd0;
    if (in_ring != 64'd0 && (cap - in_ring) < {39'd0, sz}) skip = cap - in_ring;
    start_pos = (aligned + skip) & POS_MASK;
    stop_pos = (start_pos + {39'd0, sz}) & POS_MASK;
    lag = ({32'd0, head_q} - {32'd0, tail_q}) & POS_MASK;
    if (lag <= cap && (lag + pad + skip + {39'd0, sz}) <= cap) begin
      head_q = stop_pos[END_W-1:0];
      res.ok = 1'b1;
      res.offset = OFFSET_W'(start_pos & (cap - 64'd1));
      res.end_position = stop_pos[END_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    arr_result_t want;
    if (rst) begin
      cap_log2_q = CAP_LOG2_RESET;
      head_q = '0;
      tail_q = '0;
      expected_grants.delete();
    end else begin
      if (cfg_valid && cfg_ready) cap_log2_q = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatches++;
        end else begin
          want = expected_grants.pop_front();
          if (ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, ok);
            mismatches++;
          end
          if (offset !== want.offset) begin
            $error("offset: expected %0d, got %0d", want.offset, offset);
            mismatches++;
          end
          if (end_position !== want.end_position) begin
            $error("end_position: expected %0d, got %0d", want.end_position, end_position);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_grants.push_back(allocate(op, request_size, align_log2, release_position));
      end
    end
    outstanding <= expected_grants.size();
    failures <= mismatches;
  end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import arr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int SINK_HOLD_CYCLES = 150;
  localparam int NUM_PHASES       = 11;
  localparam int PHASE_ITEMS      = 110;
  localparam int HOLD_PHASE       = 2;
  localparam int STEADY_PHASE     = 4;
  localparam int PAUSE_PHASE      = 6;
  localparam logic [NUM_PHASES-1:0][CFG_W-1:0] PHASE_CAPS =
    {5'd1, 5'd12, 5'd7, 5'd20, 5'd16, 5'd10, 5'd3, 5'd25, 5'd31, 5'd0, 5'd4};
  localparam logic [END_W-1:0] RING = 32'h0100_0000;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic                op;
  logic [SIZE_W-1:0]   request_size;
  logic [ALIGN_W-1:0]  align_log2;
  logic [REL_W-1:0]    release_position;
  logic                out_valid;
  logic                out_ready;
  logic                ok;
  logic [OFFSET_W-1:0] offset;
  logic [END_W-1:0]    end_position;
  int                  outstanding;
  int                  failures;

  logic                steady_mode;
  logic                sink_hold;
  logic                hold_done;
  logic                sent_ops [$];
  logic [END_W-1:0]    live_ends [$];
  logic [END_W-1:0]    newest_end;

  aligned_ring_reserve_core u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .op               (op),
    .request_size     (request_size),
    .align_log2       (align_log2),
    .release_position (release_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .ok               (ok),
    .offset           (offset),
    .end_position     (end_position)
  );

  ring_reserve_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // track granted end positions so that most random-phase releases follow real reservations
  always @(negedge clk) begin
    logic kind;
    if (rst) begin
      sent_ops.delete();
      live_ends.delete();
      newest_end = '0;
    end else begin
      if (out_valid && out_ready && sent_ops.size() > 0) begin
        kind = sent_ops.pop_front();
        if (kind == OP_RESERVE && ok) begin
          live_ends.push_back(end_position);
          newest_end = end_position;
        end
      end
      if (in_valid && in_ready) sent_ops.push_back(op);
    end
  end

  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold && !hold_done) begin
        out_ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES - 1) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= steady_mode || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_request(input logic kind, input logic [SIZE_W-1:0] sz,
                              input logic [ALIGN_W-1:0] al, input logic [REL_W-1:0] pos);
    int gap;
    if (!steady_mode && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    op               <= kind;
    request_size     <= sz;
    align_log2       <= al;
    release_position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int r, r2, eff, capb, picks;
    logic [SIZE_W-1:0]  sz;
    logic [ALIGN_W-1:0] al;
    logic [REL_W-1:0]   pos;
    rst              = 1'b1;
    cfg_valid        = 1'b0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    op               = OP_RESERVE;
    request_size     = '0;
    align_log2       = '0;
    release_position = '0;
    steady_mode      = 1'b0;
    sink_hold        = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // full-ring strides from zero carry the head around the 32-bit wrap
    write_capacity(CAP_LOG2_MAX);
    for (int k = 0; k < 256; k++) begin
      send_request(OP_RESERVE, SIZE_W'(RING), ALIGN_W'($urandom_range(0, 12)), $urandom);
      send_request(OP_RELEASE, SIZE_W'($urandom_range(0, 16777216)),
                   ALIGN_W'($urandom_range(0, 12)), REL_W'((k + 1) << 24));
    end

    send_request(OP_RESERVE, 0, 0, $urandom);
    send_request(OP_RESERVE, 100, 0, $urandom);
    send_request(OP_RESERVE, 1, 12, $urandom);
    send_request(OP_RESERVE, SIZE_W'(RING), 0, $urandom);
    send_request(OP_RELEASE, 0, 0, 4097);
    send_request(OP_RESERVE, SIZE_W'(RING), 0, $urandom);
    send_request(OP_RESERVE, SIZE_W'(RING - 4097), 0, $urandom);
    send_request(OP_RESERVE, 0, 12, $urandom);
    send_request(OP_RELEASE, 0, 0, RING);
    send_request(OP_RESERVE, SIZE_W'(RING - 100), 0, $urandom);
    send_request(OP_RELEASE, 0, 0, 2 * RING - 100);
    send_request(OP_RESERVE, 200, 0, $urandom);
    send_request(OP_RESERVE, SIZE_W'(RING), 0, $urandom);
    send_request(OP_RELEASE, 0, 0, 32'hFFFF_FFFF);
    send_request(OP_RESERVE, 0, 0, $urandom);
    send_request(OP_RELEASE, 0, 0, 2 * RING + 200);
    send_request(OP_RESERVE, 5, 3, $urandom);
    send_request(OP_RESERVE, 3, 3, $urandom);
    send_request(OP_RELEASE, 0, 0, 2 * RING + 211);
    send_request(OP_RESERVE, SIZE_W'(RING - 211), 0, $urandom);
    send_request(OP_RELEASE, 0, 0, 3 * RING);
    send_request(OP_RESERVE, SIZE_W'(RING), 12, $urandom);
    send_request(OP_RESERVE, 0, 0, $urandom);
    send_request(OP_RESERVE, 1, 0, $urandom);
    send_request(OP_RELEASE, 0, 0, 4 * RING);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_capacity(PHASE_CAPS[ph]);
      eff = PHASE_CAPS[ph];
      if (eff < CAP_LOG2_MIN) eff = CAP_LOG2_MIN;
      if (eff > CAP_LOG2_MAX) eff = CAP_LOG2_MAX;
      capb = 1 << eff;
      steady_mode <= (ph == STEADY_PHASE);
      if (ph == HOLD_PHASE) sink_hold <= 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == PAUSE_PHASE && k == PHASE_ITEMS / 2) wait_drained();
        r = $urandom_range(0, 99);
        if (r < 6) begin
          send_request(OP_RELEASE, SIZE_W'($urandom_range(0, 16777216)),
                       ALIGN_W'($urandom_range(0, 12)), $urandom);
        end else if (r < 38) begin
          if (live_ends.size() == 0 || r < 12) begin
            pos = newest_end;
            live_ends.delete();
          end else begin
            picks = $urandom_range(1, live_ends.size());
            repeat (picks) pos = live_ends.pop_front();
          end
          send_request(OP_RELEASE, SIZE_W'($urandom_range(0, 16777216)),
                       ALIGN_W'($urandom_range(0, 12)), pos);
        end else begin
          r2 = $urandom_range(0, 99);
          if (r2 < 5)
            sz = '0;
          else if (r2 < 60)
            sz = SIZE_W'($urandom_range(1, capb / 4));
          else if (r2 < 85)
            sz = SIZE_W'($urandom_range(capb / 4, capb));
          else if (r2 < 95)
            sz = SIZE_W'($urandom_range(0, 16777216));
          else
            sz = SIZE_W'($urandom_range(capb, 16777216));
          if ($urandom_range(0, 3) == 0)
            al = ALIGN_W'($urandom_range(0, 12));
          else
            al = ALIGN_W'($urandom_range(0, 3));
          send_request(OP_RESERVE, sz, al, $urandom);
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (failures == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
